@@ rtl/fprl_pkg.sv @@
// ----------------------------------------------------------------------------
// fprl_pkg
// Types and codes shared by the flash page ring log pointer block.
// ----------------------------------------------------------------------------
package fprl_pkg;

	// Operation codes of an input transaction.
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_CHECK  = 2'd2;

	// Flash command codes of a result transaction.
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_ERASE = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_FIRST_PAGE = 2'd0;
	localparam logic [1:0] CFG_LAST_PAGE  = 2'd1;

	// Reset values of the ring bounds.
	localparam logic [7:0] FIRST_PAGE_RST = 8'd90;
	localparam logic [7:0] LAST_PAGE_RST  = 8'd127;

	// One result transaction.
	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  page;
		logic [15:0] offset;
		logic [12:0] byte_count;
		logic        exhausted;
		logic        caught_up;
		logic        last_of_run;
	} res_t;

	// Results produced by one accepted input, handed to the output queue.
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

endpackage

@@ rtl/fprl_if.sv @@
// ----------------------------------------------------------------------------
// fprl_if
// Valid/ready channels for operation requests and flash command results.
// ----------------------------------------------------------------------------
interface fprl_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [12:0] length;

	modport source (output valid, output operation, output length, input ready);
	modport sink (input valid, input operation, input length, output ready);
endinterface

interface fprl_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  page;
	logic [15:0] offset;
	logic [12:0] byte_count;
	logic        exhausted;
	logic        caught_up;
	logic        last_of_run;

	modport source (output valid, output command, output page, output offset,
		output byte_count, output exhausted, output caught_up, output last_of_run,
		input ready);
	modport sink (input valid, input command, input page, input offset,
		input byte_count, input exhausted, input caught_up, input last_of_run,
		output ready);
endinterface

@@ rtl/fprl_core.sv @@
// ----------------------------------------------------------------------------
// fprl_core
// Ring bound registers, pointer state and the single-pass update per request.
// ----------------------------------------------------------------------------
module fprl_core import fprl_pkg::*; #(
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        take,
	input  logic [1:0]  operation,
	input  logic [12:0] length,
	output push_t       push
);

	localparam logic [16:0] PAGE_LIM = 17'(PAGE_BYTES);

	logic [7:0]  first_page_q, last_page_q;
	logic [7:0]  write_page_q, read_page_q;
	logic [15:0] write_offset_q, read_offset_q;
	logic        wrapped_q, caught_q;

	logic [7:0]  wp_d, rp_d;
	logic [15:0] wo_d, ro_d;
	logic        wrapped_d, caught_d;
	logic [16:0] w_sum, r_sum;
	logic [15:0] w_sat, r_sat;
	logic [8:0]  w_inc;
	logic [7:0]  r_next, wp_next_rd;
	logic        exh;

	// Next page in the ring, compared at nine bits.
	function automatic logic [7:0] ring_next(input logic [7:0] p, input logic [7:0] first,
		input logic [7:0] last);
		logic [8:0] n;
		n = {1'b0, p} + 9'd1;
		if (n > {1'b0, last}) begin
			return first;
		end
		return n[7:0];
	endfunction

	// Saturating pointer sums.
	assign w_sum = {1'b0, write_offset_q} + {4'd0, length};
	assign r_sum = {1'b0, read_offset_q} + {4'd0, length};
	assign w_sat = w_sum[16] ? 16'hFFFF : w_sum[15:0];
	assign r_sat = r_sum[16] ? 16'hFFFF : r_sum[15:0];
	assign w_inc = {1'b0, write_page_q} + 9'd1;
	assign r_next = ring_next(read_page_q, first_page_q, last_page_q);

	// Next state and result transactions for the request at the input.
	always_comb begin
		wp_d = write_page_q;
		wo_d = write_offset_q;
		rp_d = read_page_q;
		ro_d = read_offset_q;
		wrapped_d = wrapped_q;
		caught_d = caught_q;
		exh = 1'b0;
		wp_next_rd = 8'd0;
		push = '0;
		push.v0 = take;
		push.r0.last_of_run = 1'b1;
		case (operation)
			OP_APPEND: begin
				wo_d = w_sat;
				push.r0.command = CMD_WRITE;
				push.r0.page = write_page_q;
				push.r0.offset = write_offset_q;
				push.r0.byte_count = length;
				push.r0.caught_up = caught_q;
				if ({1'b0, w_sat} >= PAGE_LIM) begin
					if (w_inc > {1'b0, last_page_q}) begin
						wp_d = first_page_q;
						wrapped_d = 1'b1;
					end else begin
						wp_d = w_inc[7:0];
					end
					wo_d = 16'd0;
					wp_next_rd = ring_next(wp_d, first_page_q, last_page_q);
					if (wrapped_d) begin
						rp_d = wp_next_rd;
					end
					push.r0.last_of_run = 1'b0;
					push.v1 = take;
					push.r1.command = CMD_ERASE;
					push.r1.page = wp_d;
					push.r1.offset = 16'd0;
					push.r1.byte_count = PAGE_LIM[12:0];
					push.r1.exhausted = 1'b0;
					push.r1.caught_up = caught_q;
					push.r1.last_of_run = 1'b1;
				end
			end
			OP_READ: begin
				ro_d = r_sat;
				if ({1'b0, r_sat} >= PAGE_LIM) begin
					if (!caught_q) begin
						rp_d = r_next;
						ro_d = 16'd0;
						if (r_next == write_page_q) begin
							caught_d = 1'b1;
						end
					end else begin
						exh = 1'b1;
					end
				end
				push.r0.command = CMD_READ;
				push.r0.page = read_page_q;
				push.r0.offset = read_offset_q;
				push.r0.byte_count = length;
				push.r0.exhausted = exh;
				push.r0.caught_up = caught_d;
			end
			OP_CHECK: begin
				if (read_page_q == write_page_q) begin
					caught_d = 1'b1;
				end
				push.r0.command = CMD_NONE;
				push.r0.caught_up = caught_d;
			end
			default: begin
				push.r0.command = CMD_NONE;
				push.r0.caught_up = caught_q;
			end
		endcase
	end

	// Ring bound registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_page_q <= FIRST_PAGE_RST;
			last_page_q <= LAST_PAGE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_PAGE: first_page_q <= cfg_data;
				CFG_LAST_PAGE: last_page_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Pointer state, updated once per accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_page_q <= FIRST_PAGE_RST;
			read_page_q <= FIRST_PAGE_RST;
			write_offset_q <= 16'd0;
			read_offset_q <= 16'd0;
			wrapped_q <= 1'b0;
			caught_q <= 1'b0;
		end else if (take) begin
			write_page_q <= wp_d;
			read_page_q <= rp_d;
			write_offset_q <= wo_d;
			read_offset_q <= ro_d;
			wrapped_q <= wrapped_d;
			caught_q <= caught_d;
		end
	end

endmodule

@@ rtl/fprl_outq.sv @@
// ----------------------------------------------------------------------------
// fprl_outq
// Four-entry result queue that takes one or two results and drains one.
// ----------------------------------------------------------------------------
module fprl_outq import fprl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	res_t       entry_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [1:0] wr_inc;

	// Room for the two results that an append may bring.
	assign room = (cnt_q <= 3'd2);
	assign out_valid = (cnt_q != 3'd0);
	assign out_res = entry_q[rd_q];
	assign pop = out_valid && out_ready;
	assign wr_inc = wr_q + 2'd1;

	// Result storage.
	always_ff @(posedge clk) begin
		if (push.v0) begin
			entry_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			entry_q[wr_inc] <= push.r1;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 2'd0;
			rd_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q <= wr_q + {1'b0, push.v0} + {1'b0, push.v1};
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'd0, push.v0} + {2'd0, push.v1} - {2'd0, pop};
		end
	end

endmodule

@@ rtl/flash_page_ring_log_pointers.sv @@
// ----------------------------------------------------------------------------
// flash_page_ring_log_pointers
// Write and read pointers over a ring of flash pages, issuing flash commands.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake     Contents
// in_ch     sink       valid/ready   operation, length
// out_ch    source     valid/ready   command, page, offset, byte_count, flags
// cfg       write      cfg_we        cfg_index, cfg_data (first_page, last_page)
//
// A request is taken in any cycle in which the four-entry result queue has
// room for two results; the pointer update completes at that same edge.
// A read or check yields one result, an append crossing a page end yields two.
// Sustained rate is one request per cycle while the sink drains, bounded by
// the single output port: an append with an erase puts both its results on it.
// Reset puts both pointers on page 90 and empties the queue.
// ----------------------------------------------------------------------------
module flash_page_ring_log_pointers import fprl_pkg::*; #(
	parameter int PAGE_BYTES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	fprl_in_if.sink          in_ch,
	fprl_out_if.source       out_ch,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data
);

	push_t push;
	logic  room;
	logic  take;
	res_t  out_res;

	assign in_ch.ready = room;
	assign take = in_ch.valid && room;

	// Pointer state and request decode.
	fprl_core #(
		.PAGE_BYTES(PAGE_BYTES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.take(take),
		.operation(in_ch.operation),
		.length(in_ch.length),
		.push(push)
	);

	// Result queue toward the flash side.
	fprl_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_res(out_res)
	);

	assign out_ch.command = out_res.command;
	assign out_ch.page = out_res.page;
	assign out_ch.offset = out_res.offset;
	assign out_ch.byte_count = out_res.byte_count;
	assign out_ch.exhausted = out_res.exhausted;
	assign out_ch.caught_up = out_res.caught_up;
	assign out_ch.last_of_run = out_res.last_of_run;

	// An accepted transaction always leaves a result behind.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_ch.valid)
		else $error("accepted transaction left no result");

	// A second result only comes with a write first and an erase last.
	a_pair_shape: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> (push.v0 && !push.r0.last_of_run && push.r0.command == CMD_WRITE
			&& push.r1.command == CMD_ERASE))
		else $error("malformed result pair");

	// Back pressure on the input only while results are pending.
	a_stall_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> out_ch.valid)
		else $error("input stalled with empty queue");

	// Exhausted is only reported on a read once caught up.
	a_exhausted_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.exhausted) |-> (out_ch.caught_up
			&& out_ch.command == CMD_READ))
		else $error("exhausted flag on wrong result");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flash page ring log pointer block.
// Requests go in over the valid/ready input channel while a scoreboard
// follows the write and read pointers, predicts every flash command and
// compares it with what comes out. The run moves through several ring
// bounds, random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb;
	import fprl_pkg::*;

	localparam int PAGE_BYTES = 4096;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Tracks the ring pointers and holds the flash commands still to come.
	class ring_log_tracker;
		logic [7:0]  first_pg, last_pg, wr_page, rd_page;
		logic [15:0] wr_off, rd_off;
		logic        wrapped, caught;
		res_t        due[$];
		int          fails, shown, compared, requests;
		int          erases, exhausted_reads, pinned_reads;

		function new();
			first_pg = FIRST_PAGE_RST;
			last_pg  = LAST_PAGE_RST;
			wr_page  = FIRST_PAGE_RST;
			rd_page  = FIRST_PAGE_RST;
			wr_off   = '0;
			rd_off   = '0;
			wrapped  = 1'b0;
			caught   = 1'b0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] val);
			if (idx == CFG_FIRST_PAGE)
				first_pg = val;
			else if (idx == CFG_LAST_PAGE)
				last_pg = val;
		endfunction

		// Page after p, falling back to the first page past the last one.
		function logic [7:0] next_ring_page(logic [7:0] p);
			logic [8:0] n;
			n = {1'b0, p} + 9'd1;
			if (n > {1'b0, last_pg})
				return first_pg;
			return n[7:0];
		endfunction

		function logic [15:0] offset_add(logic [15:0] a, logic [12:0] b);
			logic [16:0] s;
			s = {1'b0, a} + {4'b0, b};
			return s[16] ? 16'hFFFF : s[15:0];
		endfunction

		function res_t command_of(logic [1:0] cmd, logic [7:0] pg, logic [15:0] off,
			logic [12:0] cnt, logic exh, logic last);
			res_t r;
			r.command     = cmd;
			r.page        = pg;
			r.offset      = off;
			r.byte_count  = cnt;
			r.exhausted   = exh;
			r.caught_up   = caught;
			r.last_of_run = last;
			return r;
		endfunction

		// Advances the pointers for one accepted request and queues its commands.
		function void note_request(logic [1:0] op, logic [12:0] len);
			logic [7:0]  pg0;
			logic [15:0] off0;
			logic [8:0]  n;
			logic        exh;
			requests++;
			case (op)
				OP_APPEND: begin
					pg0 = wr_page;
					off0 = wr_off;
					wr_off = offset_add(wr_off, len);
					if (wr_off >= PAGE_BYTES) begin
						n = {1'b0, wr_page} + 9'd1;
						if (n > {1'b0, last_pg}) begin
							wr_page = first_pg;
							wrapped = 1'b1;
						end else begin
							wr_page = n[7:0];
						end
						wr_off = '0;
						if (wrapped)
							rd_page = next_ring_page(wr_page);
						due.push_back(command_of(CMD_WRITE, pg0, off0, len, 1'b0, 1'b0));
						due.push_back(command_of(CMD_ERASE, wr_page, '0, 13'(PAGE_BYTES),
							1'b0, 1'b1));
						erases++;
					end else begin
						due.push_back(command_of(CMD_WRITE, pg0, off0, len, 1'b0, 1'b1));
					end
				end
				OP_READ: begin
					pg0 = rd_page;
					off0 = rd_off;
					exh = 1'b0;
					rd_off = offset_add(rd_off, len);
					if (rd_off >= PAGE_BYTES) begin
						if (!caught) begin
							rd_page = next_ring_page(rd_page);
							rd_off = '0;
							if (rd_page == wr_page)
								caught = 1'b1;
						end else begin
							exh = 1'b1;
							exhausted_reads++;
						end
					end
					if (rd_off == 16'hFFFF)
						pinned_reads++;
					due.push_back(command_of(CMD_READ, pg0, off0, len, exh, 1'b1));
				end
				default: begin
					// Check and the unused code both give an empty command.
					if (op == OP_CHECK && rd_page == wr_page)
						caught = 1'b1;
					due.push_back(command_of(CMD_NONE, '0, '0, '0, 1'b0, 1'b1));
				end
			endcase
		endfunction

		// Compares one accepted command with the oldest expected one.
		function void check_command(res_t got);
			res_t exp;
			compared++;
			if (due.size() == 0) begin
				fails++;
				if (shown < 10)
					$display("ERROR: unexpected flash command cmd=%0d page=%0d off=%0d",
						got.command, got.page, got.offset);
				shown++;
				return;
			end
			exp = due.pop_front();
			if (got.command !== exp.command || got.page !== exp.page ||
				got.offset !== exp.offset || got.byte_count !== exp.byte_count ||
				got.exhausted !== exp.exhausted || got.caught_up !== exp.caught_up ||
				got.last_of_run !== exp.last_of_run) begin
				fails++;
				if (shown < 10) begin
					$display("ERROR: command %0d expected cmd=%0d page=%0d off=%0d cnt=%0d",
						compared, exp.command, exp.page, exp.offset, exp.byte_count);
					$display("       exh=%0b cu=%0b last=%0b, got cmd=%0d page=%0d off=%0d",
						exp.exhausted, exp.caught_up, exp.last_of_run,
						got.command, got.page, got.offset);
					$display("       cnt=%0d exh=%0b cu=%0b last=%0b",
						got.byte_count, got.exhausted, got.caught_up, got.last_of_run);
				end
				shown++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	int         send_idle, recv_idle;
	int         hold_req, hold_left;
	int         cycle_count;

	ring_log_tracker tracker = new();

	fprl_in_if  in_ch();
	fprl_out_if out_ch();

	flash_page_ring_log_pointers #(.PAGE_BYTES(PAGE_BYTES)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock with a 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit in case the block stops moving.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("flash_page_ring_log_pointers: mismatch");
		$finish;
	end

	// Output side: checks each transaction and drives ready, with a hold-off on request.
	initial begin : result_side
		res_t got;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.command     = out_ch.command;
				got.page        = out_ch.page;
				got.offset      = out_ch.offset;
				got.byte_count  = out_ch.byte_count;
				got.exhausted   = out_ch.exhausted;
				got.caught_up   = out_ch.caught_up;
				got.last_of_run = out_ch.last_of_run;
				tracker.check_command(got);
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Offers one request, with random idle cycles ahead of it, until it is accepted.
	task automatic send_request(input logic [1:0] op, input logic [12:0] len);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.operation <= op;
		in_ch.length    <= len;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		tracker.note_request(op, len);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (tracker.due.size() != 0)
			@(posedge clk);
	endtask

	// Changes the ring bounds once the block has gone quiet.
	task automatic set_ring(input logic [7:0] first, input logic [7:0] last);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FIRST_PAGE;
		cfg_data  <= first;
		@(posedge clk);
		tracker.write_reg(CFG_FIRST_PAGE, first);
		cfg_index <= CFG_LAST_PAGE;
		cfg_data  <= last;
		@(posedge clk);
		tracker.write_reg(CFG_LAST_PAGE, last);
		cfg_we <= 1'b0;
	endtask

	// Random mix weighted toward appends and reads, with lengths that cross pages.
	task automatic run_segment(input int count);
		logic [1:0]  op;
		logic [12:0] len;
		int          pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				op = OP_APPEND;
			else if (pick < 85)
				op = OP_READ;
			else if (pick < 95)
				op = OP_CHECK;
			else
				op = OP_UNUSED;
			case ($urandom_range(3))
				0: len = 13'($urandom_range(0, 4096));
				1: len = 13'($urandom_range(3000, 4096));
				2: begin
					case ($urandom_range(4))
						0: len = 13'd0;
						1: len = 13'd1;
						2: len = 13'd4095;
						3: len = 13'd4096;
						default: len = 13'd8191;
					endcase
				end
				default: len = 13'($urandom_range(0, 8191));
			endcase
			send_request(op, len);
		end
	endtask

	// Main sequence.
	initial begin
		arst_n          <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.operation <= OP_APPEND;
		in_ch.length    <= '0;
		cfg_we          <= 1'b0;
		cfg_index       <= CFG_FIRST_PAGE;
		cfg_data        <= '0;
		hold_req = 0;
		send_idle = 31;
		recv_idle = 54;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: page crossings at the reset bounds, the reader kept behind.
		send_request(OP_APPEND, 13'd0);
		send_request(OP_APPEND, 13'd4096);
		send_request(OP_APPEND, 13'd8191);
		send_request(OP_APPEND, 13'd1);
		send_request(OP_APPEND, 13'd4095);
		send_request(OP_APPEND, 13'd2048);
		send_request(OP_READ, 13'd0);
		send_request(OP_READ, 13'd4096);
		send_request(OP_CHECK, 13'd0);
		send_request(OP_UNUSED, 13'd8191);
		send_request(OP_READ, 13'd5000);
		send_request(OP_READ, 13'd1);
		send_request(OP_READ, 13'd100);

		// Directed: a two-page ring so the writer wraps and pulls the reader along.
		set_ring(8'd93, 8'd94);
		send_request(OP_APPEND, 13'd2048);
		send_request(OP_APPEND, 13'd4096);
		send_request(OP_APPEND, 13'd4096);
		send_request(OP_CHECK, 13'd4096);

		// Directed: first page above last page, with the top page number.
		set_ring(8'd255, 8'd0);
		send_request(OP_APPEND, 13'd4096);
		send_request(OP_APPEND, 13'd300);

		// Random phases, idling mostly as the receiver first, then the sender, then neither.
		set_ring(8'd0, 8'd3);
		run_segment(64);
		set_ring(8'd10, 8'd12);
		hold_req = 400;
		run_segment(64);
		send_idle = 54;
		recv_idle = 31;
		set_ring(8'd5, 8'd5);
		run_segment(64);
		set_ring(8'd0, 8'd255);
		run_segment(64);
		send_idle = 0;
		recv_idle = 0;
		set_ring(8'd200, 8'd100);
		run_segment(64);
		set_ring(FIRST_PAGE_RST, LAST_PAGE_RST);
		run_segment(64);

		wait_drained();
		repeat (16) @(posedge clk);

		$display("Ran %0d requests over eight ring settings: %0d page erases, %0d exhausted reads.",
			tracker.requests, tracker.erases, tracker.exhausted_reads);
		$display("Compared %0d flash commands; read offset pinned at its ceiling %0d times.",
			tracker.compared, tracker.pinned_reads);
		if (tracker.fails == 0 && tracker.due.size() == 0) begin
			$display("flash_page_ring_log_pointers: match");
		end else begin
			$display("flash_page_ring_log_pointers: mismatch");
		end
		$finish;
	end

endmodule
